### rtl/tccci_pkg.sv
// Shared types and constants for the three-channel clamped curve interpolator.
`default_nettype none
package tccci_pkg;
    localparam int DEFAULT_MAX_KNOTS = 64;
    localparam int DEFAULT_CHANNELS  = 3;
    localparam int TABLE_CHANNELS    = 3;
    localparam int WORD_W            = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_KNOT_COUNT = 1'b0;
    localparam logic CFG_AXIS_GAMMA = 1'b1;

    localparam logic [6:0]  KNOT_COUNT_RESET = 7'd1;
    localparam logic [15:0] AXIS_GAMMA_RESET = 16'd256;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         knot_index;
        logic signed [31:0] knot_axis;
        logic signed [31:0] knot_cyan;
        logic signed [31:0] knot_magenta;
        logic signed [31:0] knot_yellow;
        logic signed [31:0] query_exposure_0;
        logic signed [31:0] query_exposure_1;
        logic signed [31:0] query_exposure_2;
    } in_t;

    typedef struct packed {
        logic signed [31:0] density_0;
        logic signed [31:0] density_1;
        logic signed [31:0] density_2;
    } out_t;
endpackage
`default_nettype wire

### rtl/three_channel_clamped_curve_interp_unit.sv
// Top level: knot table, sequencer and shared multiply/divide datapath.
// A load is written into the table when it is accepted. An interpolated channel searches the
// knots in turn, then takes up to 10 normalise steps and 31 divide steps; a clamped channel
// skips the search and the divide. A query's time from accept to result is set by the single
// registered table read port, the one-bit-a-cycle divider and the one multiplier. No new
// request is taken while a query runs. Reset clears control and configuration state; the
// knot table is not cleared and reads undefined until written.
`default_nettype none
module three_channel_clamped_curve_interp_unit #(
    parameter int MAX_KNOTS = tccci_pkg::DEFAULT_MAX_KNOTS,
    parameter int CHANNELS  = tccci_pkg::DEFAULT_CHANNELS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire tccci_pkg::in_t in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output tccci_pkg::out_t     out_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_index,
    input  wire logic [15:0]    cfg_data
);
    localparam int AW  = $clog2(MAX_KNOTS);
    localparam int NCH = (CHANNELS < tccci_pkg::TABLE_CHANNELS) ? CHANNELS
                                                               : tccci_pkg::TABLE_CHANNELS;
    localparam int EW  = 4 * tccci_pkg::WORD_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL_XG  = 4'd1;
    localparam logic [3:0] S_FIRST_W = 4'd2;
    localparam logic [3:0] S_FIRST   = 4'd3;
    localparam logic [3:0] S_LAST_W  = 4'd4;
    localparam logic [3:0] S_LAST    = 4'd5;
    localparam logic [3:0] S_SRCH_W  = 4'd6;
    localparam logic [3:0] S_SRCH    = 4'd7;
    localparam logic [3:0] S_LO_W    = 4'd8;
    localparam logic [3:0] S_LO      = 4'd9;
    localparam logic [3:0] S_HI_W    = 4'd10;
    localparam logic [3:0] S_HI      = 4'd11;
    localparam logic [3:0] S_NORM    = 4'd12;
    localparam logic [3:0] S_DIV     = 4'd13;
    localparam logic [3:0] S_MUL_P   = 4'd14;
    localparam logic [3:0] S_FIN     = 4'd15;

    logic [EW-1:0] mem [MAX_KNOTS];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;

    logic [3:0]  state_reg, state_next;
    logic [6:0]  kcount_reg;
    logic [15:0] gamma_reg;
    logic        busy_done_reg, busy_done_next;
    logic        out_valid_reg;
    tccci_pkg::out_t out_reg;

    logic [1:0]  ch_reg, ch_next;
    logic [AW:0] n_reg, n_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic signed [31:0] x_reg [3];
    logic signed [31:0] dens_reg [3];
    logic signed [31:0] dens_val;
    logic               dens_we;
    logic signed [31:0] first_ax_reg, first_ax_next;
    logic signed [31:0] first_y_reg, first_y_next;
    logic signed [31:0] a0_reg, a0_next;
    logic signed [31:0] y0_reg, y0_next;
    logic signed [32:0] diff_reg, diff_next;
    logic [40:0] num_reg, num_next;
    logic [40:0] den_reg, den_next;
    logic [31:0] rem_reg, rem_next;
    logic [30:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic signed [66:0] prod_reg, prod_next;

    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [49:0] xg;
    logic signed [31:0] rd_axis;
    logic signed [31:0] rd_chan;
    logic signed [49:0] rd_scaled;
    logic [15:0] g_eff;
    logic [10:0] kc_wide;
    logic [10:0] idx_wide;
    logic        in_acc;
    logic        out_free;
    logic signed [49:0] num_full;
    logic signed [49:0] den_full;
    logic [32:0] trial;
    logic signed [66:0] rounded;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || busy_done_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign xg        = prod_reg[49:0];
    assign rd_axis   = rd_data_reg[31:0];
    assign rd_chan   = rd_data_reg[32*(ch_reg+2'd1) +: 32];
    assign rd_scaled = {{10{rd_axis[31]}}, rd_axis, 8'd0};
    assign g_eff     = (gamma_reg == 16'd0) ? 16'd256 : gamma_reg;
    assign kc_wide   = {4'd0, kcount_reg};
    assign idx_wide  = {5'd0, in_data.knot_index};
    assign rounded   = prod_reg + 67'sd536870912;

    always_ff @(posedge clk)
    begin
        if (in_acc && in_data.opcode == tccci_pkg::OP_LOAD && idx_wide < 11'(MAX_KNOTS))
        begin
            mem[AW'(in_data.knot_index)] <= {in_data.knot_yellow, in_data.knot_magenta,
                                             in_data.knot_cyan, in_data.knot_axis};
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_comb
    begin
        if (state_reg == S_MUL_XG)
        begin
            mul_a = 34'(x_reg[ch_reg]);
            mul_b = {17'd0, g_eff};
        end
        else
        begin
            mul_a = 34'(diff_reg);
            mul_b = {2'b00, quo_reg};
        end
    end

    always_comb
    begin
        num_full = xg - {{10{a0_reg[31]}}, a0_reg, 8'd0};
        den_full = {{10{rd_axis[31]}}, rd_axis, 8'd0} - {{10{a0_reg[31]}}, a0_reg, 8'd0};
        trial    = (cnt_reg == 5'd0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    end

    always_comb
    begin
        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        busy_done_next = busy_done_reg;
        ch_next        = ch_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        first_ax_next  = first_ax_reg;
        first_y_next   = first_y_reg;
        a0_next        = a0_reg;
        y0_next        = y0_reg;
        diff_next      = diff_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        dens_we        = 1'b0;
        dens_val       = y0_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_data.opcode == tccci_pkg::OP_QUERY)
                begin
                    ch_next = 2'd0;
                    if (kcount_reg == 7'd0)
                        n_next = (AW+1)'(1);
                    else if (kc_wide > 11'(MAX_KNOTS))
                        n_next = (AW+1)'(MAX_KNOTS);
                    else
                        n_next = (AW+1)'(kc_wide);
                    state_next = S_MUL_XG;
                end
            end
            S_MUL_XG:
            begin
                prod_next    = mul_a * mul_b;
                rd_addr_next = '0;
                state_next   = S_FIRST_W;
            end
            S_FIRST_W: state_next = S_FIRST;
            S_FIRST:
            begin
                first_ax_next = rd_axis;
                first_y_next  = rd_chan;
                rd_addr_next  = AW'(n_reg - (AW+1)'(1));
                state_next    = S_LAST_W;
            end
            S_LAST_W: state_next = S_LAST;
            S_LAST:
            begin
                if (xg <= $signed({{10{first_ax_reg[31]}}, first_ax_reg, 8'd0}))
                begin
                    dens_we  = 1'b1;
                    dens_val = first_y_reg;
                end
                else if (xg >= rd_scaled)
                begin
                    dens_we  = 1'b1;
                    dens_val = rd_chan;
                end
                else
                begin
                    idx_next     = AW'(1);
                    rd_addr_next = AW'(1);
                    state_next   = S_SRCH_W;
                end
            end
            S_SRCH_W: state_next = S_SRCH;
            S_SRCH:
            begin
                if (rd_scaled >= xg)
                begin
                    lo_next      = idx_reg - AW'(1);
                    rd_addr_next = idx_reg - AW'(1);
                    state_next   = S_LO_W;
                end
                else if ((AW+1)'(idx_reg) == n_reg - (AW+1)'(1))
                begin
                    lo_next      = '0;
                    rd_addr_next = '0;
                    state_next   = S_LO_W;
                end
                else
                begin
                    idx_next     = idx_reg + AW'(1);
                    rd_addr_next = idx_reg + AW'(1);
                    state_next   = S_SRCH_W;
                end
            end
            S_LO_W: state_next = S_LO;
            S_LO:
            begin
                a0_next      = rd_axis;
                y0_next      = rd_chan;
                rd_addr_next = lo_reg + AW'(1);
                state_next   = S_HI_W;
            end
            S_HI_W: state_next = S_HI;
            S_HI:
            begin
                diff_next = 33'(rd_chan) - 33'(y0_reg);
                den_next  = den_full[40:0];
                if (num_full < 50'sd0)
                    num_next = '0;
                else if (num_full > den_full)
                    num_next = den_full[40:0];
                else
                    num_next = num_full[40:0];
                if (rd_axis <= a0_reg)
                begin
                    dens_we  = 1'b1;
                    dens_val = y0_reg;
                end
                else
                    state_next = S_NORM;
            end
            S_NORM:
            begin
                if (den_reg[40:31] != 10'd0)
                begin
                    num_next = num_reg >> 1;
                    den_next = den_reg >> 1;
                end
                else
                begin
                    rem_next   = num_reg[31:0];
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (trial >= {2'b00, den_reg[30:0]})
                begin
                    rem_next = 32'(trial - {2'b00, den_reg[30:0]});
                    quo_next = {quo_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                    state_next = S_MUL_P;
            end
            S_MUL_P:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                dens_we  = 1'b1;
                dens_val = y0_reg + rounded[61:30];
            end
            default: state_next = S_IDLE;
        endcase
        if (dens_we)
        begin
            if (ch_reg == 2'(NCH - 1))
            begin
                busy_done_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                ch_next    = ch_reg + 2'd1;
                state_next = S_MUL_XG;
            end
        end
        if (busy_done_reg && out_free)
            busy_done_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            kcount_reg    <= tccci_pkg::KNOT_COUNT_RESET;
            gamma_reg     <= tccci_pkg::AXIS_GAMMA_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            busy_done_reg <= busy_done_next;
            if (busy_done_reg && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tccci_pkg::CFG_KNOT_COUNT: kcount_reg <= cfg_data[6:0];
                    tccci_pkg::CFG_AXIS_GAMMA: gamma_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        ch_reg       <= ch_next;
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        lo_reg       <= lo_next;
        first_ax_reg <= first_ax_next;
        first_y_reg  <= first_y_next;
        a0_reg       <= a0_next;
        y0_reg       <= y0_next;
        diff_reg     <= diff_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
        if (in_acc && in_data.opcode == tccci_pkg::OP_QUERY)
        begin
            x_reg[0] <= in_data.query_exposure_0;
            x_reg[1] <= in_data.query_exposure_1;
            x_reg[2] <= in_data.query_exposure_2;
            dens_reg[0] <= '0;
            dens_reg[1] <= '0;
            dens_reg[2] <= '0;
        end
        else if (dens_we)
            dens_reg[ch_reg] <= dens_val;
        if (busy_done_reg && out_free)
        begin
            out_reg.density_0 <= dens_reg[0];
            out_reg.density_1 <= dens_reg[1];
            out_reg.density_2 <= dens_reg[2];
        end
    end
endmodule
`default_nettype wire

### test/tb_three_channel_clamped_curve_interp_unit.sv
// Self-checking bench for the three-channel clamped curve interpolator: knot loads, queries, config.
`default_nettype none
module tb_three_channel_clamped_curve_interp_unit;

    localparam int LIMIT = 20000;

    class density_scoreboard;
        logic signed [31:0] axis_tab[64];
        logic signed [31:0] dens_tab[3][64];
        logic [6:0]         knot_count;
        logic [15:0]        axis_gamma;
        tccci_pkg::out_t    pending[$];
        int                 errors;
        int                 queries;

        function new();
            knot_count = tccci_pkg::KNOT_COUNT_RESET;
            axis_gamma = tccci_pkg::AXIS_GAMMA_RESET;
            errors = 0;
            queries = 0;
            foreach (axis_tab[i])
            begin
                axis_tab[i] = 0;
                dens_tab[0][i] = 0;
                dens_tab[1][i] = 0;
                dens_tab[2][i] = 0;
            end
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == tccci_pkg::CFG_KNOT_COUNT)
                knot_count = val[6:0];
            else
                axis_gamma = val;
        endfunction

        function longint floor30(longint r);
            return r >>> 30;
        endfunction

        function logic signed [31:0] curve(int ch, longint x, longint g, int n);
            longint xg, a0, a1, y0, y1, num, den, t30;
            int lo;
            xg = x * g;
            lo = 0;
            if (xg <= longint'(axis_tab[0]) * 256)
                return dens_tab[ch][0];
            if (xg >= longint'(axis_tab[n-1]) * 256)
                return dens_tab[ch][n-1];
            for (int i = 1; i < n; i++)
            begin
                if (longint'(axis_tab[i]) * 256 >= xg)
                begin
                    lo = i - 1;
                    break;
                end
            end
            a0 = axis_tab[lo];
            a1 = axis_tab[lo+1];
            y0 = dens_tab[ch][lo];
            y1 = dens_tab[ch][lo+1];
            if (a1 <= a0)
                return y0;
            num = xg - a0 * 256;
            den = (a1 - a0) * 256;
            if (num < 0)
                num = 0;
            if (num > den)
                num = den;
            while (den >= 64'sh80000000)
            begin
                num = num >>> 1;
                den = den >>> 1;
            end
            t30 = (num <<< 30) / den;
            return y0 + floor30((y1 - y0) * t30 + (64'sd1 <<< 29));
        endfunction

        function void note_request(tccci_pkg::in_t r);
            int n;
            longint g;
            tccci_pkg::out_t e;
            if (r.opcode == tccci_pkg::OP_LOAD)
            begin
                axis_tab[r.knot_index] = r.knot_axis;
                dens_tab[0][r.knot_index] = r.knot_cyan;
                dens_tab[1][r.knot_index] = r.knot_magenta;
                dens_tab[2][r.knot_index] = r.knot_yellow;
                return;
            end
            n = knot_count;
            if (n < 1)
                n = 1;
            if (n > 64)
                n = 64;
            g = (axis_gamma == 0) ? 256 : axis_gamma;
            e.density_0 = curve(0, r.query_exposure_0, g, n);
            e.density_1 = curve(1, r.query_exposure_1, g, n);
            e.density_2 = curve(2, r.query_exposure_2, g, n);
            pending.push_back(e);
            queries++;
        endfunction

        function void check_result(tccci_pkg::out_t a);
            tccci_pkg::out_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.density_0 !== e.density_0)
            begin
                $error("density_0 exp %0d got %0d", e.density_0, a.density_0);
                errors++;
            end
            if (a.density_1 !== e.density_1)
            begin
                $error("density_1 exp %0d got %0d", e.density_1, a.density_1);
                errors++;
            end
            if (a.density_2 !== e.density_2)
            begin
                $error("density_2 exp %0d got %0d", e.density_2, a.density_2);
                errors++;
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    tccci_pkg::in_t  in_data;
    logic            out_valid;
    logic            out_stall;
    tccci_pkg::out_t out_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic            cfg_index;
    logic [15:0]     cfg_data;

    density_scoreboard sb;
    int  idle_cycles;
    bit  hold_off;
    bit  sent_all;
    int  known;   // knots written so far (0..known-1 all written)

    three_channel_clamped_curve_interp_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // valid stays high after an accept until the next request or an explicit drop
    task automatic send(tccci_pkg::in_t r);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return $urandom_range(0, 1) ? 32'sh0 : -32'sd1;
            3: return $signed($urandom_range(0, 65535)) - 32768;
            default: return $urandom();
        endcase
    endfunction

    function automatic tccci_pkg::in_t load_req(int idx, logic signed [31:0] ax);
        tccci_pkg::in_t r;
        r = '0;
        r.opcode = tccci_pkg::OP_LOAD;
        r.knot_index = 6'(idx);
        r.knot_axis = ax;
        r.knot_cyan = rnd32();
        r.knot_magenta = rnd32();
        r.knot_yellow = rnd32();
        r.query_exposure_0 = $urandom();
        r.query_exposure_1 = $urandom();
        r.query_exposure_2 = $urandom();
        return r;
    endfunction

    function automatic logic signed [31:0] probe(int n);
        logic signed [31:0] a;
        int i;
        i = $urandom_range(0, n - 1);
        a = sb.axis_tab[i];
        case ($urandom_range(0, 4))
            0: return rnd32();
            1: return a;
            2: return a + $signed($urandom_range(0, 4096)) - 2048;
            default: return sb.axis_tab[0] + $signed($urandom_range(0, 32'h3fffffff));
        endcase
    endfunction

    function automatic tccci_pkg::in_t query_req(int n);
        tccci_pkg::in_t r;
        r = '0;
        r.opcode = tccci_pkg::OP_QUERY;
        r.knot_index = 6'($urandom());
        r.knot_axis = $urandom();
        r.knot_cyan = $urandom();
        r.knot_magenta = $urandom();
        r.knot_yellow = $urandom();
        r.query_exposure_0 = probe(n);
        r.query_exposure_1 = probe(n);
        r.query_exposure_2 = probe(n);
        return r;
    endfunction

    // build a curve of n knots: mostly increasing, sometimes flat or disordered
    task automatic load_curve(int n, int style);
        logic signed [31:0] ax;
        int step;
        ax = (style == 3) ? 32'sh80000000 : $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
        step = (style == 3) ? 32'h7ffffff : $urandom_range(1, 32'h40000);
        for (int i = 0; i < n; i++)
        begin
            send(load_req(i, ax));
            if (style == 1 && $urandom_range(0, 3) == 0)
                ax = ax;
            else if (style == 2)
                ax = $urandom();
            else
                ax = ax + $signed($urandom_range(1, step));
        end
        if (n > known)
            known = n;
    endtask

    task automatic phase(int count_reg, logic [15:0] gamma, int style, int nq);
        int n;
        drain();
        write_reg(tccci_pkg::CFG_KNOT_COUNT, 16'(count_reg));
        write_reg(tccci_pkg::CFG_AXIS_GAMMA, gamma);
        n = count_reg < 1 ? 1 : (count_reg > 64 ? 64 : count_reg);
        load_curve(n, style);
        for (int i = 0; i < nq; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send(load_req($urandom_range(0, n - 1), probe(n)));
            send(query_req(n));
        end
    endtask

    initial
    begin
        tccci_pkg::in_t r;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_index = tccci_pkg::CFG_KNOT_COUNT;
        cfg_data = '0;
        sent_all = 0;
        known = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: single knot at reset settings, extremes, flat and disordered curves
        r = load_req(0, 32'sh80000000);
        send(r);
        known = 1;
        r = query_req(1);
        r.query_exposure_0 = 32'sh80000000;
        r.query_exposure_1 = 32'sh7fffffff;
        r.query_exposure_2 = 0;
        send(r);
        phase(0, 16'd0, 0, 3);
        phase(4, 16'hffff, 0, 4);
        phase(5, 16'd1, 1, 4);
        phase(6, 16'd256, 2, 4);
        phase(127, 16'd256, 3, 4);
        phase(64, 16'd128, 0, 4);
        for (int p = 0; p < 39; p++)
        begin
            case ($urandom_range(0, 9))
                0: phase(64, 16'($urandom()), $urandom_range(0, 3), 25);
                1: phase($urandom_range(65, 127), 16'd256, 0, 25);
                default: phase($urandom_range(1, 12),
                               16'($urandom_range(0, 3) == 0 ? $urandom()
                                                             : $urandom_range(64, 1024)),
                               $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3), 25);
            endcase
        end
        in_valid <= 1'b0;
        sent_all = 1;
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        int g;
        out_stall = 1'b0;
        hold_off = 0;
        wait (rst_n);
        repeat (3000) @(posedge clk);
        hold_off = 1;
        out_stall <= 1'b1;
        repeat (4000) @(posedge clk);
        hold_off = 0;
        forever
        begin
            out_stall <= 1'b0;
            @(posedge clk);
            g = gap_len();
            if (g > 0)
            begin
                out_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    initial
    begin
        idle_cycles = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
                || hold_off)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (sent_all && sb.pending.size() == 0)
            begin
                repeat (400) @(posedge clk);
                $display("Covered %0d queries over %0d-knot tables with gamma and count sweeps.",
                         sb.queries, known);
                if (sb.errors == 0)
                    $display("DONE: 0 errors");
                else
                    $display("DONE: errors detected");
                $finish;
            end
            else if (idle_cycles >= LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire

### filelist.f
rtl/tccci_pkg.sv
rtl/three_channel_clamped_curve_interp_unit.sv
test/tb_three_channel_clamped_curve_interp_unit.sv
